>>> rtl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// bgr_pkg: shared types and constants for the bilinear grid resampler
// Operation codes, register indexes, datapath widths and the 32-bit
// saturation helper.
// ----------------------------------------------------------------------------
package bgr_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [2:0] cfg_idx_t;

  // operation codes carried by the mode field
  localparam mode_t MODE_WRITE   = 2'd0;
  localparam mode_t MODE_READ    = 2'd1;
  localparam mode_t MODE_FORWARD = 2'd2;
  localparam mode_t MODE_ADJOINT = 2'd3;

  // register indexes
  localparam cfg_idx_t CFG_GRID_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_GRID_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_ORIGIN_X    = 3'd2;
  localparam cfg_idx_t CFG_ORIGIN_Y    = 3'd3;
  localparam cfg_idx_t CFG_STEP_X      = 3'd4;
  localparam cfg_idx_t CFG_STEP_Y      = 3'd5;
  localparam cfg_idx_t CFG_GAIN        = 3'd6;
  localparam cfg_idx_t CFG_WRAP        = 3'd7;

  // shared multiplier operand and product widths
  localparam int AW = 38;
  localparam int BW = 22;
  localparam int MW = AW + BW;
  // position width: Q16.16 origin plus 12 x 24 bit offset
  localparam int PW = 38;

  localparam logic signed [MW-1:0] SAT_HI = MW'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [MW-1:0] SAT_LO = MW'(-64'sh0000_0000_8000_0000);

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/bilinear_grid_resampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_grid_resampler_core: bilinear resampling over a stored grid
// Word write goes straight to S_DONE; word read passes S_RDW then S_DONE.
// Forward sample and adjoint scatter share one multiplier; the scatter
// does four read-modify-writes through the grid RAM, via S_R0 to S_R2.
// With wrap on, the modulo unit steps through all UW dividend bits (25 at
// the default size); an off-grid point goes from S_FIX to S_DONE. One item
// at a time: the next transfer can be taken in the cycle the result is
// presented. Sync reset clears control, loads config defaults; RAM undefined.
// ----------------------------------------------------------------------------
module bilinear_grid_resampler_core #(
  parameter int GRID_DIM_MAX = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  bgr_pkg::mode_t       mode,
  input  logic [7:0]           grid_col,
  input  logic [7:0]           grid_row,
  input  logic [11:0]          out_x,
  input  logic [11:0]          out_y,
  input  logic signed [31:0]   data_value,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [31:0]   result_value,
  output logic                 point_missing,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  bgr_pkg::cfg_idx_t    cfg_index,
  input  logic [31:0]          cfg_data
);
  import bgr_pkg::*;

  localparam int CW    = $clog2(GRID_DIM_MAX);
  localparam int DIMW  = $clog2(GRID_DIM_MAX + 1);
  localparam int UW    = ((DIMW + 15 > 22) ? DIMW + 15 : 22) + 1;
  localparam int CNTW  = $clog2(UW + 1);
  localparam int DEPTH = 1 << (2 * CW);
  localparam int IPW   = PW - 16;

  localparam logic [4:0] S_IDLE = 5'd0,  S_RDW  = 5'd1,  S_LOCX = 5'd2,  S_LOCY = 5'd3;
  localparam logic [4:0] S_LOCP = 5'd4,  S_PREP = 5'd5,  S_WRAP = 5'd6,  S_FIX  = 5'd7;
  localparam logic [4:0] S_F0   = 5'd8,  S_F1   = 5'd9,  S_F2   = 5'd10, S_F3   = 5'd11;
  localparam logic [4:0] S_F4   = 5'd12, S_F5   = 5'd13, S_F6   = 5'd14, S_F7   = 5'd15;
  localparam logic [4:0] S_F8   = 5'd16, S_F9   = 5'd17, S_A0   = 5'd18, S_A1   = 5'd19;
  localparam logic [4:0] S_A2   = 5'd20, S_A3   = 5'd21, S_A4   = 5'd22, S_A5   = 5'd23;
  localparam logic [4:0] S_R0   = 5'd24, S_R1   = 5'd25, S_R2   = 5'd26, S_DONE = 5'd27;

  // configuration registers
  logic [8:0]         grid_width, grid_height;
  logic signed [31:0] origin_x, origin_y;
  logic [23:0]        step_x, step_y;
  logic signed [20:0] gain;
  logic               wrap_enable;

  logic [4:0] state, state_next;
  logic       accept;

  // latched item
  mode_t              mode_q;
  logic signed [31:0] data_q;
  logic [11:0]        ox_q, oy_q;
  logic               ok_q;

  // locate datapath
  logic signed [PW-1:0]  pos_x, pos_y;
  logic signed [IPW-1:0] ip_x, ip_y;
  logic [UW-1:0]         ux, uy;
  logic [DIMW-1:0]       rem_x, rem_y;
  logic [DIMW:0]         trial_x, trial_y;
  logic [CNTW-1:0]       cnt;
  logic [DIMW-1:0]       eff_w, eff_h;
  logic signed [31:0]    ipx32, ipy32, szm1_x, szm1_y;
  logic                  miss_x, miss_y, miss;
  logic [CW-1:0]         c0x, c1x, c0y, c1y;
  logic [CW-1:0]         x0, x1, y0, y1;
  logic [15:0]           fx, fy;
  logic [16:0]           gx, gy;

  // arithmetic
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [MW-1:0] prod, acc, acc_sum;
  logic signed [31:0]   c0, c1, v, cur;
  logic signed [36:0]   t_s;
  logic [16:0]          wgt [4];
  logic [1:0]           k;

  // result holding
  logic signed [31:0] hold;
  logic               miss_hold;

  // grid memory
  logic signed [31:0]  mem [DEPTH];
  logic signed [31:0]  rdata, wdata;
  logic [2*CW-1:0]     raddr, waddr, in_addr;
  logic                we, ok_in;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  // effective grid sizes
  always_comb begin
    if (grid_width < 9'd2) begin
      eff_w = DIMW'(2);
    end else if (32'(grid_width) > GRID_DIM_MAX) begin
      eff_w = DIMW'(GRID_DIM_MAX);
    end else begin
      eff_w = DIMW'(grid_width);
    end
    if (grid_height < 9'd2) begin
      eff_h = DIMW'(2);
    end else if (32'(grid_height) > GRID_DIM_MAX) begin
      eff_h = DIMW'(GRID_DIM_MAX);
    end else begin
      eff_h = DIMW'(grid_height);
    end
  end

  assign ok_in   = (32'(grid_col) < GRID_DIM_MAX) && (32'(grid_row) < GRID_DIM_MAX);
  assign in_addr = {CW'(grid_row), CW'(grid_col)};

  // cell and fraction from position
  assign ip_x    = pos_x[PW-1:16];
  assign ip_y    = pos_y[PW-1:16];
  assign ipx32   = 32'(ip_x);
  assign ipy32   = 32'(ip_y);
  assign szm1_x  = $signed(32'(eff_w)) - 32'sd1;
  assign szm1_y  = $signed(32'(eff_h)) - 32'sd1;
  assign miss_x  = (ipx32 < 0) || (ipx32 > szm1_x) ||
                   ((ipx32 == szm1_x) && (pos_x[15:0] != 16'd0));
  assign miss_y  = (ipy32 < 0) || (ipy32 > szm1_y) ||
                   ((ipy32 == szm1_y) && (pos_y[15:0] != 16'd0));
  assign miss    = !wrap_enable && (miss_x || miss_y);
  assign c0x     = wrap_enable ? CW'(rem_x) : CW'(ip_x);
  assign c0y     = wrap_enable ? CW'(rem_y) : CW'(ip_y);
  assign c1x     = ($signed(32'(c0x)) == szm1_x) ? '0 : CW'(c0x + 1'b1);
  assign c1y     = ($signed(32'(c0y)) == szm1_y) ? '0 : CW'(c0y + 1'b1);
  assign trial_x = {rem_x, ux[UW-1]};
  assign trial_y = {rem_y, uy[UW-1]};
  assign gx      = 17'h10000 - 17'(fx);
  assign gy      = 17'h10000 - 17'(fy);
  assign acc_sum = acc + prod;

  // sequencer, multiplier operands and memory port control
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    raddr      = in_addr;
    we         = 1'b0;
    waddr      = in_addr;
    wdata      = data_value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_WRITE: begin
              we         = ok_in;
              state_next = S_DONE;
            end
            MODE_READ: state_next = S_RDW;
            default:   state_next = S_LOCX;
          endcase
        end
      end
      S_RDW:  state_next = S_DONE;
      S_LOCX: begin
        mul_a      = AW'(step_x);
        mul_b      = BW'(ox_q);
        state_next = S_LOCY;
      end
      S_LOCY: begin
        mul_a      = AW'(step_y);
        mul_b      = BW'(oy_q);
        state_next = S_LOCP;
      end
      S_LOCP: state_next = S_PREP;
      S_PREP: state_next = wrap_enable ? S_WRAP : S_FIX;
      S_WRAP: begin
        if (cnt == CNTW'(1)) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        if (miss) begin
          state_next = S_DONE;
        end else if (mode_q == MODE_FORWARD) begin
          state_next = S_F0;
        end else begin
          state_next = S_A0;
        end
      end
      // forward: column x0 blended over y, then column x1, then over x
      S_F0: begin
        raddr      = {y0, x0};
        state_next = S_F1;
      end
      S_F1: begin
        raddr      = {y1, x0};
        mul_a      = AW'(rdata);
        mul_b      = BW'(gy);
        state_next = S_F2;
      end
      S_F2: begin
        raddr      = {y0, x1};
        mul_a      = AW'(rdata);
        mul_b      = BW'(fy);
        state_next = S_F3;
      end
      S_F3: begin
        raddr      = {y1, x1};
        mul_a      = AW'(rdata);
        mul_b      = BW'(gy);
        state_next = S_F4;
      end
      S_F4: begin
        mul_a      = AW'(rdata);
        mul_b      = BW'(fy);
        state_next = S_F5;
      end
      S_F5: begin
        mul_a      = AW'(c0);
        mul_b      = BW'(gx);
        state_next = S_F6;
      end
      S_F6: begin
        mul_a      = AW'(c1);
        mul_b      = BW'(fx);
        state_next = S_F7;
      end
      S_F7: state_next = S_F8;
      S_F8: begin
        mul_a      = AW'(v);
        mul_b      = BW'(gain);
        state_next = S_F9;
      end
      S_F9: state_next = S_DONE;
      // adjoint: scaled sample, then the four weights
      S_A0: begin
        mul_a      = AW'(data_q);
        mul_b      = BW'(gain);
        state_next = S_A1;
      end
      S_A1: begin
        mul_a      = AW'(gx);
        mul_b      = BW'(gy);
        state_next = S_A2;
      end
      S_A2: begin
        mul_a      = AW'(fx);
        mul_b      = BW'(gy);
        state_next = S_A3;
      end
      S_A3: begin
        mul_a      = AW'(gx);
        mul_b      = BW'(fy);
        state_next = S_A4;
      end
      S_A4: begin
        mul_a      = AW'(fx);
        mul_b      = BW'(fy);
        state_next = S_A5;
      end
      S_A5: state_next = S_R0;
      // read-modify-write of one cell, cells never overlap in time
      S_R0: begin
        raddr      = {(k[1] ? y1 : y0), (k[0] ? x1 : x0)};
        state_next = S_R1;
      end
      S_R1: begin
        mul_a      = AW'(t_s);
        mul_b      = BW'(wgt[k]);
        state_next = S_R2;
      end
      S_R2: begin
        we         = 1'b1;
        waddr      = {(k[1] ? y1 : y0), (k[0] ? x1 : x0)};
        wdata      = sat32(MW'(cur) + (prod >>> 16));
        state_next = (k == 2'd3) ? S_DONE : S_R0;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // grid RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control state, output valid and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      grid_width   <= 9'd256;
      grid_height  <= 9'd256;
      origin_x     <= '0;
      origin_y     <= '0;
      step_x       <= 24'd65536;
      step_y       <= 24'd65536;
      gain         <= 21'sd65536;
      wrap_enable  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data[8:0];
          CFG_GRID_HEIGHT: grid_height <= cfg_data[8:0];
          CFG_ORIGIN_X:    origin_x    <= cfg_data;
          CFG_ORIGIN_Y:    origin_y    <= cfg_data;
          CFG_STEP_X:      step_x      <= cfg_data[23:0];
          CFG_STEP_Y:      step_y      <= cfg_data[23:0];
          CFG_GAIN:        gain        <= cfg_data[20:0];
          CFG_WRAP:        wrap_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= MW'(mul_a * mul_b);
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      result_value  <= hold;
      point_missing <= miss_hold;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q    <= mode;
          data_q    <= data_value;
          ox_q      <= out_x;
          oy_q      <= out_y;
          ok_q      <= ok_in;
          hold      <= '0;
          miss_hold <= 1'b0;
        end
      end
      S_RDW:  hold  <= ok_q ? rdata : 32'sd0;
      S_LOCY: pos_x <= PW'(origin_x) + PW'(prod);
      S_LOCP: pos_y <= PW'(origin_y) + PW'(prod);
      S_PREP: begin
        // bias by size << 15 keeps the dividend non-negative
        ux    <= UW'(ip_x) + (UW'(eff_w) << 15);
        uy    <= UW'(ip_y) + (UW'(eff_h) << 15);
        rem_x <= '0;
        rem_y <= '0;
        cnt   <= CNTW'(UW);
      end
      S_WRAP: begin
        // restoring remainder, one dividend bit per cycle
        rem_x <= (trial_x >= {1'b0, eff_w}) ? DIMW'(trial_x - {1'b0, eff_w})
                                            : DIMW'(trial_x);
        rem_y <= (trial_y >= {1'b0, eff_h}) ? DIMW'(trial_y - {1'b0, eff_h})
                                            : DIMW'(trial_y);
        ux    <= ux << 1;
        uy    <= uy << 1;
        cnt   <= cnt - 1'b1;
      end
      S_FIX: begin
        x0        <= c0x;
        x1        <= c1x;
        y0        <= c0y;
        y1        <= c1y;
        fx        <= pos_x[15:0];
        fy        <= pos_y[15:0];
        miss_hold <= miss;
        hold      <= (miss && mode_q == MODE_FORWARD) ? data_q : 32'sd0;
      end
      S_F2, S_F4, S_F6: acc <= prod;
      S_F3: c0 <= acc_sum[47:16];
      S_F5: c1 <= acc_sum[47:16];
      S_F7: v  <= acc_sum[47:16];
      S_F9: hold <= sat32(MW'(data_q) + (prod >>> 16));
      S_A1: t_s <= prod[52:16];
      S_A2: wgt[0] <= prod[32:16];
      S_A3: wgt[1] <= prod[32:16];
      S_A4: wgt[2] <= prod[32:16];
      S_A5: begin
        wgt[3] <= prod[32:16];
        k      <= 2'd0;
      end
      S_R1: cur <= rdata;
      S_R2: k   <= k + 1'b1;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start");

  // grid writes only from a write item or the scatter write-back
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE || state == S_R2))
    else $error("unexpected grid write");

  // located cells lie inside the effective grid
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_F0 || state == S_A0) |->
      (32'(x0) < 32'(eff_w) && 32'(y0) < 32'(eff_h)))
    else $error("cell outside grid");

  // a pending result is not dropped while stalled
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result lost");
`endif

endmodule
